// ===== sv/brb_pkg.sv =====
package brb_pkg;

  localparam int CNT_W      = 11;
  localparam int ALIGN_UNIT = 8;

  typedef enum logic [1:0] {
    MODE_READ   = 2'd0,
    MODE_WSTART = 2'd1,
    MODE_WDATA  = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_DATA   = 2'd0,
    STAT_WR_OK  = 2'd1,
    STAT_WR_REJ = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_BURST = 2'b10
  } state_t;

  typedef struct packed {
    logic             from_mem;
    logic             last;
    status_t          status;
    logic [CNT_W-1:0] count;
  } res_meta_t;

endpackage

// ===== sv/brb_ram.sv =====
module brb_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/byte_ring_buffer_burst.sv =====
// Byte ring buffer over a single-port-read, single-port-write memory of DEPTH bytes. Every
// request except a read burst gives at most one status result; a read burst of n bytes is
// accepted and then streams one byte per cycle from the memory read port while the memory
// stage is free, with the next request taken once the last byte is issued. Results pass
// through a memory stage and an output register, so a stalled consumer holds the burst
// without losing bytes. A capacity write or a pointer reset clears the pointers and any
// pending write burst; the store itself needs no clearing pass.
module byte_ring_buffer_burst import brb_pkg::*; #(
  parameter int DEPTH     = 1024,
  parameter int MAX_BURST = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       mode,
  input  logic [6:0]       length,
  input  logic             force_req,
  input  logic [7:0]       data_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       data_out,
  output logic             last,
  output logic [1:0]       status,
  output logic [CNT_W-1:0] count,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $clog2(MAX_BURST + 1);
  localparam int PW    = (AW > CNT_W) ? AW : CNT_W;
  localparam int LIMIT = (DEPTH / ALIGN_UNIT) * ALIGN_UNIT;

  function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] raw);
    logic [CNT_W-1:0] c;
    c = raw & ~CNT_W'(ALIGN_UNIT - 1);
    if (int'(c) > LIMIT) c = CNT_W'(LIMIT);
    if (c < CNT_W'(ALIGN_UNIT)) c = CNT_W'(ALIGN_UNIT);
    return c;
  endfunction

  state_t           state, state_next;
  logic [CNT_W-1:0] cap, cap_next;
  logic [AW-1:0]    rp, rp_next;
  logic [AW-1:0]    wp, wp_next;
  logic [CNT_W-1:0] stored, stored_next;
  logic [BW-1:0]    beats, beats_next;
  logic             pforce, pforce_next;
  logic [BW-1:0]    rem, rem_next;
  logic [BW-1:0]    bn, bn_next;
  logic             s1_valid;
  res_meta_t        s1_meta, s1_meta_next;
  logic             s1_load;

  logic             ram_we, ram_re;
  logic [7:0]       rdata;

  logic             out_load, s1_free, acc, issue;
  logic [PW:0]      rp_inc, wp_inc;
  logic [AW-1:0]    rp_adv, wp_adv;
  logic             len_over;
  logic [BW-1:0]    len_clip, rd_n;
  logic [CNT_W-1:0] room;
  logic             wr_reject;

  assign rp_inc = (PW+1)'(rp) + (PW+1)'(1);
  assign wp_inc = (PW+1)'(wp) + (PW+1)'(1);
  assign rp_adv = (rp_inc == (PW+1)'(cap)) ? '0 : rp_inc[AW-1:0];
  assign wp_adv = (wp_inc == (PW+1)'(cap)) ? '0 : wp_inc[AW-1:0];

  assign len_over  = length > 7'(MAX_BURST);
  assign len_clip  = len_over ? BW'(MAX_BURST) : length[BW-1:0];
  assign rd_n      = (CNT_W'(len_clip) > stored) ? stored[BW-1:0] : len_clip;
  assign room      = cap - stored;
  assign wr_reject = (length == 7'd0) || len_over || (beats != '0) ||
                     ((stored == cap) && !force_req) || (CNT_W'(length) > room);

  assign out_load = s1_valid && (!out_valid || out_ready);
  assign s1_free  = !s1_valid || out_load;
  assign in_ready = (state == S_IDLE) && s1_free;
  assign acc      = in_valid && in_ready;
  assign issue    = (state == S_BURST) && s1_free;

  always_comb begin
    state_next   = state;
    cap_next     = cap;
    rp_next      = rp;
    wp_next      = wp;
    stored_next  = stored;
    beats_next   = beats;
    pforce_next  = pforce;
    rem_next     = rem;
    bn_next      = bn;
    s1_meta_next = s1_meta;
    s1_load      = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    if (acc) begin
      case (mode_t'(mode))
        MODE_READ: begin
          if (length != 7'd0) begin
            if (stored == '0) begin
              s1_load      = 1'b1;
              s1_meta_next = '{from_mem: 1'b0, last: 1'b1, status: STAT_EMPTY, count: '0};
            end else begin
              rem_next   = rd_n;
              bn_next    = rd_n;
              state_next = S_BURST;
            end
          end
        end
        MODE_WSTART: begin
          s1_load      = 1'b1;
          s1_meta_next = '{from_mem: 1'b0, last: 1'b1,
                           status: wr_reject ? STAT_WR_REJ : STAT_WR_OK, count: stored};
          if (!wr_reject) begin
            beats_next  = len_clip;
            pforce_next = force_req;
          end
        end
        MODE_WDATA: begin
          s1_load = 1'b1;
          if (beats == '0) begin
            s1_meta_next = '{from_mem: 1'b0, last: 1'b1, status: STAT_WR_REJ, count: stored};
          end else begin
            ram_we      = 1'b1;
            wp_next     = wp_adv;
            beats_next  = beats - BW'(1);
            stored_next = stored + CNT_W'(1);
            if (beats == BW'(1)) begin
              pforce_next = 1'b0;
              if (pforce) begin
                rp_next     = wp_adv;
                stored_next = cap;
              end
            end
            s1_meta_next = '{from_mem: 1'b0, last: 1'b1, status: STAT_WR_OK,
                             count: stored_next};
          end
        end
        MODE_CLEAR: begin
          rp_next     = '0;
          wp_next     = '0;
          stored_next = '0;
          beats_next  = '0;
          pforce_next = 1'b0;
        end
        default: ;
      endcase
    end

    if (issue) begin
      ram_re       = 1'b1;
      s1_load      = 1'b1;
      rp_next      = rp_adv;
      stored_next  = stored - CNT_W'(1);
      rem_next     = rem - BW'(1);
      s1_meta_next = '{from_mem: 1'b1, last: (rem == BW'(1)), status: STAT_DATA,
                       count: (rem == BW'(1)) ? CNT_W'(bn) : stored - CNT_W'(1)};
      if (rem == BW'(1)) begin
        state_next = S_IDLE;
      end
    end

    if (cfg_we) begin
      cap_next    = eff_cap(cfg_wdata);
      rp_next     = '0;
      wp_next     = '0;
      stored_next = '0;
      beats_next  = '0;
      pforce_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cap      <= eff_cap(CNT_W'(1024));
      rp       <= '0;
      wp       <= '0;
      stored   <= '0;
      beats    <= '0;
      pforce   <= 1'b0;
      rem      <= '0;
      bn       <= '0;
      s1_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cap      <= cap_next;
      rp       <= rp_next;
      wp       <= wp_next;
      stored   <= stored_next;
      beats    <= beats_next;
      pforce   <= pforce_next;
      rem      <= rem_next;
      bn       <= bn_next;
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_meta <= s1_meta_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      data_out <= s1_meta.from_mem ? rdata : 8'd0;
      last     <= s1_meta.last;
      status   <= s1_meta.status;
      count    <= s1_meta.count;
    end
  end

  brb_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (data_in),
    .re    (ram_re),
    .raddr (rp),
    .rdata (rdata)
  );

  a_stored_in_range: assert property (@(posedge clk) disable iff (rst)
    stored <= cap)
    else $error("stored byte count above capacity");

  a_burst_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (state == S_BURST) |-> (rem != '0))
    else $error("burst state with nothing left to read");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_load) |=> (s1_valid && $stable(s1_meta)))
    else $error("memory stage result lost while output stalled");

  a_force_pending: assert property (@(posedge clk) disable iff (rst)
    pforce |-> (beats != '0))
    else $error("forced write marked with no beats pending");

endmodule

// ===== dv/byte_ring_buffer_burst_test.sv =====
`timescale 1ns / 1ps

module byte_ring_buffer_burst_test;
  import brb_pkg::*;

  localparam int RING_DEPTH  = 1024;
  localparam int BURST_MAX   = 64;
  localparam int PLAN_SIDE   = 0;
  localparam int CHECK_SIDE  = 1;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_REQS  = 40;

  typedef struct packed {
    mode_t      md;
    logic [6:0] len;
    logic       frc;
    logic [7:0] din;
  } req_t;

  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    status_t          status;
    logic [CNT_W-1:0] count;
  } beat_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       mode = 2'd0;
  logic [6:0]       length = 7'd0;
  logic             force_req = 1'b0;
  logic [7:0]       data_in = 8'd0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       data_out;
  logic             last;
  logic [1:0]       status;
  logic [CNT_W-1:0] count;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  req_t  queued_reqs [$];
  beat_t owed_beats [$];
  req_t  cur;
  beat_t want;
  int    snd_idle = 0;
  int    rcv_idle = 0;
  int    err_cnt = 0;
  int    cycles = 0;

  int         rd_ptr [2];
  int         wr_ptr [2];
  bit         full_f [2];
  int         beats_left [2];
  bit         force_pend [2];
  int         cap_eff [2];
  logic [7:0] ring_mem [2][RING_DEPTH];
  bit         seen [RING_DEPTH];

  byte_ring_buffer_burst u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .length    (length),
    .force_req (force_req),
    .data_in   (data_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_out  (data_out),
    .last      (last),
    .status    (status),
    .count     (count),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int cap_of(input int raw);
    int c;
    c = ((raw & 2047) / ALIGN_UNIT) * ALIGN_UNIT;
    if (c > (RING_DEPTH / ALIGN_UNIT) * ALIGN_UNIT) c = (RING_DEPTH / ALIGN_UNIT) * ALIGN_UNIT;
    if (c < ALIGN_UNIT) c = ALIGN_UNIT;
    return c;
  endfunction

  function automatic void buffer_clear(input int sel);
    rd_ptr[sel]     = 0;
    wr_ptr[sel]     = 0;
    full_f[sel]     = 1'b0;
    beats_left[sel] = 0;
    force_pend[sel] = 1'b0;
  endfunction

  function automatic void buffer_config(input int sel, input int raw);
    cap_eff[sel] = cap_of(raw);
    buffer_clear(sel);
  endfunction

  function automatic int buffer_level(input int sel);
    if (rd_ptr[sel] == wr_ptr[sel]) return full_f[sel] ? cap_eff[sel] : 0;
    return (wr_ptr[sel] + cap_eff[sel] - rd_ptr[sel]) % cap_eff[sel];
  endfunction

  function automatic void owe_beat(input int sel, input logic [7:0] data, input logic fin,
                                   input status_t st, input int cnt);
    beat_t b;
    b.data   = data;
    b.last   = fin;
    b.status = st;
    b.count  = CNT_W'(cnt);
    if (sel == CHECK_SIDE) owed_beats.push_back(b);
  endfunction

  function automatic void buffer_apply(input int sel, input req_t rq);
    int avail, n, i;
    avail = buffer_level(sel);
    case (rq.md)
      MODE_READ: begin
        if (rq.len != 0) begin
          if (avail == 0) begin
            owe_beat(sel, 8'd0, 1'b1, STAT_EMPTY, 0);
          end else begin
            n = (rq.len > BURST_MAX) ? BURST_MAX : int'(rq.len);
            if (n > avail) n = avail;
            for (i = 0; i < n; i++) begin
              owe_beat(sel, ring_mem[sel][rd_ptr[sel]], i == n - 1, STAT_DATA,
                       (i == n - 1) ? n : avail - i - 1);
              rd_ptr[sel] = (rd_ptr[sel] + 1) % cap_eff[sel];
            end
            full_f[sel] = 1'b0;
          end
        end
      end
      MODE_WSTART: begin
        if (rq.len == 0 || rq.len > BURST_MAX || beats_left[sel] != 0 ||
            (rd_ptr[sel] == wr_ptr[sel] && full_f[sel] && !rq.frc) ||
            rq.len > cap_eff[sel] - avail) begin
          owe_beat(sel, 8'd0, 1'b1, STAT_WR_REJ, avail);
        end else begin
          beats_left[sel] = rq.len;
          force_pend[sel] = rq.frc;
          owe_beat(sel, 8'd0, 1'b1, STAT_WR_OK, avail);
        end
      end
      MODE_WDATA: begin
        if (beats_left[sel] == 0) begin
          owe_beat(sel, 8'd0, 1'b1, STAT_WR_REJ, avail);
        end else begin
          ring_mem[sel][wr_ptr[sel]] = rq.din;
          if (sel == PLAN_SIDE) seen[wr_ptr[sel]] = 1'b1;
          wr_ptr[sel] = (wr_ptr[sel] + 1) % cap_eff[sel];
          full_f[sel] = 1'b1;
          beats_left[sel]--;
          if (beats_left[sel] == 0) begin
            if (force_pend[sel]) rd_ptr[sel] = wr_ptr[sel];
            force_pend[sel] = 1'b0;
          end
          owe_beat(sel, 8'd0, 1'b1, STAT_WR_OK, buffer_level(sel));
        end
      end
      default: begin
        buffer_clear(sel);
      end
    endcase
  endfunction

  // drop the force mark where the burst would expose bytes never written
  function automatic void plan_req(input mode_t md, input int len, input bit frc, input int din);
    req_t rq;
    int c, wp, i;
    bit safe;
    rq.md  = md;
    rq.len = len[6:0];
    rq.frc = frc;
    rq.din = din[7:0];
    if (md == MODE_WSTART && frc) begin
      c    = cap_eff[PLAN_SIDE];
      wp   = wr_ptr[PLAN_SIDE];
      safe = 1'b1;
      for (i = 0; i < c; i++) begin
        if ((i - wp + c) % c >= rq.len && !seen[i]) safe = 1'b0;
      end
      if (!safe) rq.frc = 1'b0;
    end
    queued_reqs.push_back(rq);
    buffer_apply(PLAN_SIDE, rq);
  endfunction

  function automatic void plan_random(input int n);
    int done, free, lim, r, len;
    mode_t md;
    done = 0;
    while (done < n) begin
      r    = $urandom_range(0, 99);
      free = cap_eff[PLAN_SIDE] - buffer_level(PLAN_SIDE);
      if (beats_left[PLAN_SIDE] != 0 && r < 85) begin
        plan_req(MODE_WDATA, $urandom_range(0, 127), $urandom_range(0, 1), $urandom_range(0, 255));
        done++;
      end else if (r < 45 && free > 0 && beats_left[PLAN_SIDE] == 0) begin
        lim = (free < BURST_MAX) ? free : BURST_MAX;
        if ($urandom_range(0, 3) != 0 && lim > 12) lim = 12;
        plan_req(MODE_WSTART, $urandom_range(1, lim), $urandom_range(0, 3) == 0,
                 $urandom_range(0, 255));
        done++;
      end else if (r < 85) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 16);
        plan_req(MODE_READ, len, $urandom_range(0, 1), $urandom_range(0, 255));
        done++;
      end else begin
        md  = mode_t'($urandom_range(0, 3));
        len = $urandom_range(0, 127);
        plan_req(md, len, $urandom_range(0, 1), $urandom_range(0, 255));
        if (!(md == MODE_READ && len == 0)) done++;
      end
    end
  endfunction

  task automatic wait_drained();
    while (queued_reqs.size() != 0 || in_valid || owed_beats.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_capacity(input int raw);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(raw);
    @(posedge clk);
    cfg_we    <= 1'b0;
    buffer_config(PLAN_SIDE, raw);
    buffer_config(CHECK_SIDE, raw);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) buffer_apply(CHECK_SIDE, cur);
      if (!in_valid || in_ready) begin
        if (queued_reqs.size() != 0 && $urandom_range(0, 99) >= snd_idle) begin
          cur = queued_reqs.pop_front();
          in_valid  <= 1'b1;
          mode      <= cur.md;
          length    <= cur.len;
          force_req <= cur.frc;
          data_in   <= cur.din;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_beats.size() == 0) begin
          $display("%0t: result with none due: data %0d last %0d status %0d count %0d",
                   $time, data_out, last, status, count);
          err_cnt++;
        end else begin
          want = owed_beats.pop_front();
          if (data_out !== want.data) begin
            $display("%0t: data_out expected %0d got %0d", $time, want.data, data_out);
            err_cnt++;
          end
          if (last !== want.last) begin
            $display("%0t: last expected %0d got %0d", $time, want.last, last);
            err_cnt++;
          end
          if (status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, status);
            err_cnt++;
          end
          if (count !== want.count) begin
            $display("%0t: count expected %0d got %0d", $time, want.count, count);
            err_cnt++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("byte_ring_buffer_burst_test: errors");
      $finish;
    end
  end

  initial begin
    int caps [6];
    int ph;
    caps = '{8, 16, 1024, 13, 100, 1023};
    buffer_config(PLAN_SIDE, 1024);
    buffer_config(CHECK_SIDE, 1024);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (ph = 0; ph < 6; ph++) begin
      wait_drained();
      set_capacity(caps[ph]);
      snd_idle = (ph < 2) ? 35 : (ph < 4) ? 47 : 0;
      rcv_idle = (ph < 2) ? 47 : (ph < 4) ? 35 : 0;
      if (ph == 0) begin
        plan_req(MODE_READ, 1, 1'b0, 0);
        plan_req(MODE_READ, 0, 1'b1, 255);
        plan_req(MODE_WSTART, 0, 1'b0, 0);
        plan_req(MODE_WSTART, 65, 1'b0, 0);
        plan_req(MODE_WSTART, 127, 1'b1, 0);
        plan_req(MODE_WDATA, 0, 1'b0, 8'h5a);
        plan_req(MODE_WSTART, 5, 1'b0, 0);
        plan_req(MODE_WSTART, 2, 1'b0, 0);
        plan_req(MODE_WDATA, 127, 1'b1, 8'h00);
        plan_req(MODE_WDATA, 0, 1'b0, 8'hff);
        plan_req(MODE_WDATA, 0, 1'b0, 8'h01);
        plan_req(MODE_WDATA, 0, 1'b0, 8'h80);
        plan_req(MODE_WDATA, 0, 1'b0, 8'h7f);
        plan_req(MODE_WSTART, 4, 1'b0, 0);
        plan_req(MODE_WSTART, 3, 1'b1, 0);
        plan_req(MODE_WDATA, 0, 1'b0, 8'haa);
        plan_req(MODE_WDATA, 0, 1'b0, 8'h55);
        plan_req(MODE_WDATA, 0, 1'b0, 8'hc3);
        plan_req(MODE_WSTART, 1, 1'b0, 0);
        plan_req(MODE_WSTART, 1, 1'b1, 0);
        plan_req(MODE_READ, 127, 1'b0, 0);
        plan_req(MODE_READ, 3, 1'b0, 0);
        plan_req(MODE_WSTART, 2, 1'b0, 0);
        plan_req(MODE_WDATA, 0, 1'b0, 8'h11);
        plan_req(MODE_CLEAR, 127, 1'b1, 255);
        plan_req(MODE_WDATA, 0, 1'b0, 8'h22);
        plan_req(MODE_READ, 1, 1'b0, 0);
      end
      plan_random(PHASE_REQS);
    end
    while (queued_reqs.size() != 0 || in_valid || owed_beats.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (err_cnt == 0 && owed_beats.size() == 0) begin
      $display("byte_ring_buffer_burst_test: clean");
    end else begin
      $display("byte_ring_buffer_burst_test: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/brb_pkg.sv
sv/brb_ram.sv
sv/byte_ring_buffer_burst.sv
dv/byte_ring_buffer_burst_test.sv
